// ----- rtl/iafp_pkg.sv -----
// ----------------------------------------------------------------------------
// iafp_pkg
// Shared types and constants for the angle frame parser: payload structs,
// sync and type codes, frame geometry.
// ----------------------------------------------------------------------------
package iafp_pkg;

  localparam int FRAME_LEN = 11;
  localparam int WIN_IDX_W = 4;

  localparam logic [7:0] SYNC_BYTE     = 8'h55;
  localparam logic [7:0] COMBINED_TYPE = 8'h61;
  localparam logic [7:0] ANGLE_TYPE    = 8'h53;

  localparam logic [3:0] COMBINED_LAST = 4'd7;
  localparam logic [3:0] INDEX_SAT     = 4'd8;
  localparam logic [3:0] LAST_POS      = 4'd10;

  localparam logic KIND_COMBINED = 1'b0;
  localparam logic KIND_CHECKED  = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       packet_start;
  } in_t;

  typedef struct packed {
    logic               frame_kind;
    logic signed [15:0] roll_raw;
    logic signed [15:0] pitch_raw;
    logic signed [15:0] yaw_raw;
    logic signed [15:0] temp_centi;
  } out_t;

endpackage

// ----- rtl/iafp_core.sv -----
// ----------------------------------------------------------------------------
// iafp_core
// Window state and frame detection: takes one byte per transaction, updates
// the 11-byte window and presents at most one result combinationally.
// ----------------------------------------------------------------------------
module iafp_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_accept,
  input  iafp_pkg::in_t  in_data,
  output logic           res_valid,
  output iafp_pkg::out_t res_data
);

  logic [7:0] win [iafp_pkg::FRAME_LEN];
  logic [7:0] win_w [iafp_pkg::FRAME_LEN];
  logic [3:0] fill;
  logic [3:0] fill_next;
  logic [3:0] pidx;
  logic [3:0] pidx_next;
  logic       combined;
  logic       combined_next;

  logic [3:0] fill_eff;
  logic [3:0] idx;
  logic       comb_eff;
  logic [3:0] pos;
  logic       wr_en;
  logic [3:0] wr_pos;
  logic       shift;
  logic       kind;
  logic [7:0] b;
  logic [11:0] sum_wide;
  logic [7:0] sum;

  assign b = in_data.rx_byte;

  // checksum over the ten bytes already held when the window completes
  always_comb begin
    sum_wide = '0;
    for (int k = 0; k < iafp_pkg::FRAME_LEN - 1; k++) begin
      sum_wide = sum_wide + {4'd0, win[k]};
    end
    sum = sum_wide[7:0];
  end

  always_comb begin
    fill_eff      = in_data.packet_start ? 4'd0 : fill;
    idx           = in_data.packet_start ? 4'd0 : pidx;
    comb_eff      = in_data.packet_start ? 1'b0 : combined;
    pidx_next     = (idx < iafp_pkg::INDEX_SAT) ? idx + 4'd1 : idx;
    pos           = (fill_eff > iafp_pkg::LAST_POS) ? iafp_pkg::LAST_POS : fill_eff;
    fill_next     = fill_eff;
    combined_next = comb_eff;
    wr_en         = 1'b0;
    wr_pos        = fill_eff;
    shift         = 1'b0;
    res_valid     = 1'b0;
    kind          = iafp_pkg::KIND_COMBINED;

    if (comb_eff) begin
      if (idx <= iafp_pkg::COMBINED_LAST && fill_eff <= iafp_pkg::LAST_POS) begin
        wr_en     = 1'b1;
        fill_next = fill_eff + 4'd1;
        if (idx == iafp_pkg::COMBINED_LAST && fill_eff == iafp_pkg::COMBINED_LAST) begin
          res_valid = 1'b1;
        end
      end
    end else if (idx == 4'd1 && fill_eff == 4'd1 && win[0] == iafp_pkg::SYNC_BYTE &&
                 b == iafp_pkg::COMBINED_TYPE) begin
      combined_next = 1'b1;
      wr_en         = 1'b1;
      wr_pos        = 4'd1;
      fill_next     = 4'd2;
    end else begin
      wr_en     = 1'b1;
      wr_pos    = pos;
      fill_next = pos + 4'd1;
      if (pos == iafp_pkg::LAST_POS) begin
        if (win[0] == iafp_pkg::SYNC_BYTE && sum == b) begin
          fill_next = 4'd0;
          if (win[1] == iafp_pkg::ANGLE_TYPE) begin
            res_valid = 1'b1;
            kind      = iafp_pkg::KIND_CHECKED;
          end
        end else begin
          // bad window: drop the oldest byte only
          shift     = 1'b1;
          fill_next = iafp_pkg::LAST_POS;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < iafp_pkg::FRAME_LEN; k++) begin
      win_w[k] = (wr_en && wr_pos == iafp_pkg::WIN_IDX_W'(k)) ? b : win[k];
    end
  end

  always_comb begin
    res_data.frame_kind = kind;
    res_data.roll_raw   = {win_w[3], win_w[2]};
    res_data.pitch_raw  = {win_w[5], win_w[4]};
    res_data.yaw_raw    = {win_w[7], win_w[6]};
    res_data.temp_centi = kind ? {win_w[9], win_w[8]} : 16'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      pidx     <= '0;
      combined <= 1'b0;
    end else if (in_accept) begin
      fill     <= fill_next;
      pidx     <= pidx_next;
      combined <= combined_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int k = 0; k < iafp_pkg::FRAME_LEN - 1; k++) begin
        win[k] <= shift ? win_w[k+1] : win_w[k];
      end
      win[iafp_pkg::FRAME_LEN-1] <= win_w[iafp_pkg::FRAME_LEN-1];
    end
  end

endmodule

// ----- rtl/imu_angle_frame_parser_top.sv -----
// ----------------------------------------------------------------------------
// imu_angle_frame_parser_top
// Byte-stream parser for sensor angle packets and checksummed angle frames.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one payload byte per transaction,
//     with packet_start set on the first byte of each notification packet.
//   out channel (out_valid/out_ready/out_data): one result per completed
//     combined packet (frame_kind 0) or good 0x53 frame (frame_kind 1).
//   Throughput: one byte per cycle while the skid entry is empty, from the
//     combinational window update and ten-byte checksum.
//   Output: a completed result is registered into the output register, or
//     into the skid entry while the output register waits on out_ready.
//   Stall: an output register plus one skid entry; in_ready drops only while
//     the skid entry is full, i.e. after two results wait behind out_ready.
//   Reset: clears window fill, packet index and combined mode; the first bytes
//     after reset are treated as the start of a packet. No clearing pass.
// ----------------------------------------------------------------------------
module imu_angle_frame_parser_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  iafp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output iafp_pkg::out_t out_data
);

  logic           in_accept;
  logic           res_valid;
  iafp_pkg::out_t res_data;
  logic           skid_valid;
  iafp_pkg::out_t skid_data;
  logic           res_take;

  assign in_ready  = !skid_valid;
  assign in_accept = in_valid && in_ready;
  assign res_take  = in_accept && res_valid;

  iafp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_take;
      end
    end else if (res_take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (res_take) begin
        out_data <= res_data;
      end
    end else if (res_take) begin
      skid_data <= res_data;
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output transaction pending");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready && res_take))
    else $error("skid entry filled without a stalled output");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_ready |=> skid_valid && $stable(skid_data))
    else $error("skid entry lost while output stalled");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte streams of combined angle packets, checked frames and noise
// into the angle frame parser and checks every result, field by field,
// against a cycle-free predictor of the parser kept in step with the input.
// ----------------------------------------------------------------------------
module testbench;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int BYTE_TARGET = 1100;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  iafp_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  iafp_pkg::out_t out_data;

  imu_angle_frame_parser_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [7:0] win [iafp_pkg::FRAME_LEN];
  int         win_cnt = 0;
  int         pkt_pos = 0;
  bit         in_combined = 1'b0;

  iafp_pkg::out_t pending_angles [$];
  logic [7:0] pkt [$];
  int         mismatch_count = 0;
  int         bytes_sent = 0;
  int         quiet_cycles = 0;
  int         rx_hold = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;

  function automatic iafp_pkg::out_t angle_result(logic kind);
    iafp_pkg::out_t r;
    r.frame_kind = kind;
    r.roll_raw   = {win[3], win[2]};
    r.pitch_raw  = {win[5], win[4]};
    r.yaw_raw    = {win[7], win[6]};
    r.temp_centi = (kind == iafp_pkg::KIND_CHECKED) ? {win[9], win[8]} : 16'sd0;
    return r;
  endfunction

  function automatic bit parse_byte(input iafp_pkg::in_t t, output iafp_pkg::out_t r);
    int         pos;
    logic [7:0] sum;
    r = '0;
    if (t.packet_start) begin
      win_cnt     = 0;
      pkt_pos     = 0;
      in_combined = 1'b0;
    end
    pos = pkt_pos;
    if (pkt_pos < iafp_pkg::INDEX_SAT) pkt_pos++;

    if (in_combined) begin
      if (pos <= iafp_pkg::COMBINED_LAST && win_cnt < iafp_pkg::FRAME_LEN) begin
        win[win_cnt] = t.rx_byte;
        win_cnt++;
        if (pos == iafp_pkg::COMBINED_LAST && win_cnt == iafp_pkg::COMBINED_LAST + 1) begin
          r = angle_result(iafp_pkg::KIND_COMBINED);
          return 1'b1;
        end
      end
      return 1'b0;
    end

    // second byte of a packet opening with sync selects combined mode
    if (pos == 1 && win_cnt == 1 && win[0] == iafp_pkg::SYNC_BYTE &&
        t.rx_byte == iafp_pkg::COMBINED_TYPE) begin
      in_combined = 1'b1;
      win[1]      = t.rx_byte;
      win_cnt     = 2;
      return 1'b0;
    end

    if (win_cnt >= iafp_pkg::FRAME_LEN) win_cnt = iafp_pkg::FRAME_LEN - 1;
    win[win_cnt] = t.rx_byte;
    win_cnt++;

    if (win_cnt == iafp_pkg::FRAME_LEN) begin
      sum = '0;
      for (int k = 0; k < iafp_pkg::FRAME_LEN - 1; k++) sum += win[k];
      if (win[0] == iafp_pkg::SYNC_BYTE && sum == win[iafp_pkg::FRAME_LEN - 1]) begin
        win_cnt = 0;
        if (win[1] == iafp_pkg::ANGLE_TYPE) begin
          r = angle_result(iafp_pkg::KIND_CHECKED);
          return 1'b1;
        end
      end else begin
        // slide by one byte
        for (int k = 0; k < iafp_pkg::FRAME_LEN - 1; k++) win[k] = win[k + 1];
        win_cnt = iafp_pkg::FRAME_LEN - 1;
      end
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 30)
      $display("[%0t] %s: got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_result(input iafp_pkg::out_t got);
    iafp_pkg::out_t want;
    if (pending_angles.size() == 0) begin
      report_mismatch("result with nothing expected", got.frame_kind, 0);
    end else begin
      want = pending_angles.pop_front();
      if (got.frame_kind !== want.frame_kind)
        report_mismatch("frame_kind", got.frame_kind, want.frame_kind);
      if (got.roll_raw !== want.roll_raw)
        report_mismatch("roll_raw", got.roll_raw, want.roll_raw);
      if (got.pitch_raw !== want.pitch_raw)
        report_mismatch("pitch_raw", got.pitch_raw, want.pitch_raw);
      if (got.yaw_raw !== want.yaw_raw)
        report_mismatch("yaw_raw", got.yaw_raw, want.yaw_raw);
      if (got.temp_centi !== want.temp_centi)
        report_mismatch("temp_centi", got.temp_centi, want.temp_centi);
    end
  endtask

  // predict first so a same-edge result always finds its expectation
  always @(posedge clk) begin : monitor
    iafp_pkg::out_t r;
    if (!rst) begin
      if (in_valid && in_ready && parse_byte(in_data, r)) pending_angles.push_back(r);
      if (out_valid && out_ready) check_result(out_data);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("imu_angle_frame_parser_top: mismatch");
      $finish;
    end
  end

  function automatic int idle_len(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin : rx_side
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = idle_len(rx_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    gap = idle_len(tx_idle_pct);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{rx_byte: b, packet_start: start};
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_packet(input bit start);
    foreach (pkt[i]) send_byte(pkt[i], start && i == 0);
    pkt.delete();
  endtask

  // sync, type, eight data bytes (word 0 in the low bits) and checksum
  task automatic add_frame(input logic [7:0] kind, input bit good, input logic [63:0] data);
    logic [7:0] sum;
    sum = iafp_pkg::SYNC_BYTE + kind;
    pkt.push_back(iafp_pkg::SYNC_BYTE);
    pkt.push_back(kind);
    for (int k = 0; k < 8; k++) begin
      pkt.push_back(data[8*k +: 8]);
      sum += data[8*k +: 8];
    end
    pkt.push_back(good ? sum : sum + 8'($urandom_range(1, 255)));
  endtask

  task automatic add_combined(input int len, input logic [47:0] data);
    logic [7:0] body [8];
    body[0] = iafp_pkg::SYNC_BYTE;
    body[1] = iafp_pkg::COMBINED_TYPE;
    for (int k = 0; k < 6; k++) body[k + 2] = data[8*k +: 8];
    for (int k = 0; k < len; k++) pkt.push_back(k < 8 ? body[k] : 8'($urandom));
  endtask

  task automatic add_noise(input int n);
    for (int k = 0; k < n; k++)
      pkt.push_back($urandom_range(0, 3) == 0 ? iafp_pkg::SYNC_BYTE : 8'($urandom));
  endtask

  // bytes right after reset open a packet even without the start flag
  task automatic test_reset_combined();
    add_combined(9, 48'hFFFF_7FFF_8000);
    send_packet(1'b0);
  endtask

  task automatic test_short_combined();
    add_combined(3, 48'h0);
    send_packet(1'b1);
  endtask

  // leading byte fails the window, the frame behind it must still be found
  task automatic test_checked_frame();
    pkt.push_back(8'h00);
    add_frame(iafp_pkg::ANGLE_TYPE, 1'b1, 64'h8000_FFFF_7FFF_8000);
    send_packet(1'b1);
  endtask

  task automatic test_other_type();
    add_frame(8'h51, 1'b1, {$urandom, $urandom});
    add_frame(iafp_pkg::ANGLE_TYPE, 1'b1, 64'h7FFF_0000_FFFF_0001);
    send_packet(1'b1);
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_hold     = HOLD_CYCLES;
    for (int p = 0; p < 8; p++) begin
      add_combined(8, 48'({$urandom, $urandom}));
      send_packet(1'b1);
    end
  endtask

  task automatic test_random_stream();
    int sel;
    int pkts;
    pkts = 0;
    while (bytes_sent < BYTE_TARGET) begin
      if (pkts % 40 == 0) begin
        tx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
        rx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
      end
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        if ($urandom_range(0, 99) < 85)
          add_combined(8 + $urandom_range(0, 4), 48'({$urandom, $urandom}));
        else
          add_combined($urandom_range(1, 7), 48'({$urandom, $urandom}));
      end else if (sel < 80) begin
        add_noise($urandom_range(0, 3));
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 4))
            0:       add_frame(8'($urandom), $urandom_range(0, 4) != 0, {$urandom, $urandom});
            1:       add_frame(8'($urandom_range(8'h50, 8'h5A)), $urandom_range(0, 4) != 0,
                               {$urandom, $urandom});
            default: add_frame(iafp_pkg::ANGLE_TYPE, $urandom_range(0, 4) != 0,
                               {$urandom, $urandom});
          endcase
        end
        add_noise($urandom_range(0, 2));
      end else begin
        add_noise($urandom_range(1, 14));
      end
      // an occasional packet runs on from the previous one
      send_packet($urandom_range(0, 99) < 92);
      pkts++;
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    foreach (win[k]) win[k] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_combined();
    test_short_combined();
    test_checked_frame();
    rx_idle_pct = 30;
    tx_idle_pct = 30;
    test_other_type();
    test_backpressure();
    test_random_stream();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("imu_angle_frame_parser_top: match");
    end else begin
      $display("imu_angle_frame_parser_top: mismatch");
    end
    $finish;
  end

endmodule
